// ----- rtl/slhs_pkg.sv -----
// ---------------------------------------------------------------------------
// slhs_pkg: shared types and constants for the signal level histogram
// Command codes, sequencer states and channel payload types.
// ---------------------------------------------------------------------------
`default_nettype none
package slhs_pkg;
  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_SUMMARY = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [7:0] level_dbm;
    logic              kind_ok;
    logic              level_invalid;
    logic              is_filtered;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [31:0]        bin_count;
    logic [31:0]        bin_cumulative;
    logic [31:0]        total_count;
    logic signed [15:0] mean_q8;
    logic signed [7:0]  median_dbm;
    logic signed [7:0]  mode_dbm;
    logic signed [7:0]  min_dbm;
    logic signed [7:0]  max_dbm;
    logic               is_empty;
  } out_item_t;

  localparam logic [7:0] LOWEST_RESET  = 8'hFF;
  localparam logic [7:0] HIGHEST_RESET = 8'h00;
endpackage
`default_nettype wire

// ----- rtl/slhs_if.sv -----
// ---------------------------------------------------------------------------
// slhs_in_if / slhs_out_if: valid/ready channels
// One transfer moves one item when valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none
interface slhs_in_if;
  logic valid;
  logic ready;
  slhs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface slhs_out_if;
  logic valid;
  logic ready;
  slhs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/signal_level_histogram_stats.sv -----
// ---------------------------------------------------------------------------
// signal_level_histogram_stats: 256-bin level histogram with statistics
// Counts qualified samples, reports one bin or a summary of the histogram.
// ---------------------------------------------------------------------------
// Add sample: read on transfer, read again, increment and write back.
// Bin readout: one bin per cycle through the single memory read port; summary adds a
// 49-step restoring divider for the mean.
// Clear command: one bin per cycle; a rejected sample is taken and dropped without leaving idle.
// After reset a clearing pass over all bins runs before any transfer.
// Results wait in an output register; the next item is taken once it leaves.
`default_nettype none
module signal_level_histogram_stats #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  slhs_in_if.sink        in_ch,
  slhs_out_if.source     out_ch
);
  localparam int NBINS = 256;
  localparam int SUMW  = COUNT_BITS + 9;
  localparam int DIVW  = SUMW + 8;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  slhs_pkg::state_t state, state_next;

  logic [COUNT_BITS-1:0] mem [NBINS];
  logic [COUNT_BITS-1:0] rd_data;
  logic [7:0]            rd_addr, wr_addr;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] wr_data;

  logic [8:0]            idx;
  logic [7:0]            bin_sel;
  logic [1:0]            cmd;
  logic [7:0]            lowest_bin, highest_bin;
  logic [COUNT_BITS-1:0] sample_total;
  logic signed [SUMW-1:0] level_sum;
  logic [COUNT_BITS-1:0] cum, best, sel_count, sel_cum;
  logic [7:0]            median, mode;
  logic                  found;
  logic [DIVW-1:0]       quo;
  logic [COUNT_BITS:0]   rem;
  logic [5:0]            dcnt;
  logic                  out_valid;
  slhs_pkg::out_item_t   out_data;
  slhs_pkg::out_item_t   out_result;

  // Memory: one write, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic [COUNT_BITS:0]   cum_sum;
  logic [COUNT_BITS-1:0] cum_sat;
  assign cum_sum = {1'b0, cum} + {1'b0, rd_data};
  assign cum_sat = cum_sum[COUNT_BITS] ? CMAX : cum_sum[COUNT_BITS-1:0];

  logic [SUMW-1:0] mag;
  assign mag = level_sum[SUMW-1] ? SUMW'(-level_sum) : SUMW'(level_sum);

  logic [COUNT_BITS:0] rem_sh, rem_sub;
  assign rem_sh  = {rem[COUNT_BITS-1:0], quo[DIVW-1]};
  assign rem_sub = rem_sh - {1'b0, sample_total};

  logic [7:0] scan_bin;
  logic       scan_data;
  assign scan_bin  = idx[7:0] - 8'd1;
  assign scan_data = (idx != 9'd0);

  always_comb begin
    state_next = state;
    rd_addr = idx[7:0];
    wr_en = 1'b0;
    wr_addr = idx[7:0];
    wr_data = '0;
    unique case (state)
      slhs_pkg::ST_IDLE: begin
        rd_addr = in_ch.data.level_dbm ^ 8'h80;
        if (in_ch.valid && !out_valid) begin
          case (in_ch.data.cmd)
            slhs_pkg::CMD_ADD:
              if (in_ch.data.kind_ok && !in_ch.data.level_invalid &&
                  !in_ch.data.is_filtered) state_next = slhs_pkg::ST_ADD_RD;
            slhs_pkg::CMD_CLEAR: state_next = slhs_pkg::ST_CLEAR;
            default: state_next = slhs_pkg::ST_SCAN;
          endcase
        end
      end
      slhs_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        if (idx == 9'd255) state_next = slhs_pkg::ST_IDLE;
      end
      slhs_pkg::ST_ADD_RD: begin
        // keep the selected bin on the read port for the write-back cycle
        rd_addr = bin_sel;
        state_next = slhs_pkg::ST_ADD_WR;
      end
      slhs_pkg::ST_ADD_WR: begin
        wr_en = 1'b1;
        wr_addr = bin_sel;
        wr_data = (rd_data == CMAX) ? CMAX : rd_data + 1'b1;
        state_next = slhs_pkg::ST_IDLE;
      end
      slhs_pkg::ST_SCAN:
        if (idx == 9'd256)
          state_next = (cmd == slhs_pkg::CMD_SUMMARY && sample_total != '0) ?
                       slhs_pkg::ST_DIV : slhs_pkg::ST_OUT;
      slhs_pkg::ST_DIV: if (dcnt == 6'(DIVW - 1)) state_next = slhs_pkg::ST_OUT;
      slhs_pkg::ST_OUT: state_next = slhs_pkg::ST_IDLE;
      default: state_next = slhs_pkg::ST_IDLE;
    endcase
  end

  // Assemble the result item for the output register
  always_comb begin
    out_result = '0;
    if (cmd == slhs_pkg::CMD_READ) begin
      out_result.bin_count = 32'(sel_count);
      out_result.bin_cumulative = 32'(sel_cum);
    end else begin
      out_result.result_kind = 1'b1;
      if (sample_total == '0) out_result.is_empty = 1'b1;
      else begin
        out_result.total_count = 32'(sample_total);
        out_result.mean_q8 = level_sum[SUMW-1] ? -quo[15:0] : quo[15:0];
        out_result.median_dbm = median ^ 8'h80;
        out_result.mode_dbm = mode ^ 8'h80;
        out_result.min_dbm = lowest_bin ^ 8'h80;
        out_result.max_dbm = highest_bin ^ 8'h80;
      end
    end
  end

  assign in_ch.ready = (state == slhs_pkg::ST_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slhs_pkg::ST_CLEAR;
      idx <= '0;
      out_valid <= 1'b0;
      lowest_bin <= slhs_pkg::LOWEST_RESET;
      highest_bin <= slhs_pkg::HIGHEST_RESET;
      sample_total <= '0;
      level_sum <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        slhs_pkg::ST_IDLE: begin
          idx <= '0;
          cmd <= in_ch.data.cmd;
          bin_sel <= in_ch.data.level_dbm ^ 8'h80;
          if (state_next == slhs_pkg::ST_CLEAR) begin
            lowest_bin <= slhs_pkg::LOWEST_RESET;
            highest_bin <= slhs_pkg::HIGHEST_RESET;
            sample_total <= '0;
            level_sum <= '0;
          end
          cum <= '0; best <= '0; found <= 1'b0;
          median <= 8'hFF; mode <= '0;
        end
        slhs_pkg::ST_CLEAR: idx <= idx + 9'd1;
        slhs_pkg::ST_ADD_WR: begin
          if (bin_sel < lowest_bin) lowest_bin <= bin_sel;
          if (bin_sel > highest_bin) highest_bin <= bin_sel;
          if (sample_total != CMAX) begin
            sample_total <= sample_total + 1'b1;
            level_sum <= level_sum + SUMW'($signed(bin_sel ^ 8'h80));
          end
        end
        slhs_pkg::ST_SCAN: begin
          idx <= idx + 9'd1;
          if (scan_data) begin
            cum <= cum_sat;
            if (scan_bin == bin_sel) begin
              sel_count <= rd_data;
              sel_cum <= cum_sat;
            end
            if (!found && cum_sat > (sample_total >> 1)) begin
              found <= 1'b1;
              median <= scan_bin;
            end
            if (rd_data > best) begin
              best <= rd_data;
              mode <= scan_bin;
            end
          end
          quo <= {mag, 8'd0};
          rem <= '0;
          dcnt <= '0;
        end
        slhs_pkg::ST_DIV: begin
          dcnt <= dcnt + 6'd1;
          if (!rem_sub[COUNT_BITS]) begin
            rem <= rem_sub;
            quo <= {quo[DIVW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[DIVW-2:0], 1'b0};
          end
        end
        slhs_pkg::ST_OUT: begin
          out_valid <= 1'b1;
          out_data <= out_result;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != slhs_pkg::ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    (sample_total != '0) |-> (lowest_bin <= highest_bin)) else $error("min above max");
`endif
endmodule
`default_nettype wire

// ----- sim/tb_signal_level_histogram_stats.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_signal_level_histogram_stats: self-checking bench for the level histogram
// Drives add, summary, bin read and clear commands over the input channel,
// predicts every bin readout and summary from a local histogram copy and
// checks each output transfer field by field, under varied idling and
// backpressure on both channels.
// ---------------------------------------------------------------------------
module tb_signal_level_histogram_stats;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int PHASE_ITEMS    = 440;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slhs_in_if  in_ch ();
  slhs_out_if out_ch ();

  signal_level_histogram_stats uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // Local copy of the histogram state
  logic [31:0]        hist_bins [256];
  logic [7:0]         low_bin;
  logic [7:0]         high_bin;
  logic [31:0]        counted;
  logic signed [40:0] level_total;

  slhs_pkg::out_item_t expected_results [$];

  int error_count   = 0;
  int sender_idle   = 0;   // percent of cycles the sender idles
  int receiver_stall = 0;  // percent of cycles the receiver stalls
  bit hold_off      = 1'b0;
  int idle_cycles   = 0;
  logic signed [7:0] focus_level = 8'sd0;

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic clear_histogram();
    for (int b = 0; b < 256; b++) hist_bins[b] = '0;
    low_bin     = slhs_pkg::LOWEST_RESET;
    high_bin    = slhs_pkg::HIGHEST_RESET;
    counted     = '0;
    level_total = '0;
  endtask

  // Apply one accepted item to the local histogram; queue its result, if any
  task automatic apply_item(slhs_pkg::in_item_t it);
    slhs_pkg::out_item_t res;
    logic [7:0]  bin;
    logic [31:0] cum;
    logic [31:0] best;
    logic [7:0]  med;
    logic [7:0]  mod;
    bit          found;
    logic [63:0] mag;
    logic [63:0] q;
    logic [15:0] mean;
    bin = it.level_dbm ^ 8'h80;
    res = '0;
    case (it.cmd)
      slhs_pkg::CMD_CLEAR: begin
        clear_histogram();
      end
      slhs_pkg::CMD_ADD: begin
        if (it.kind_ok && !it.level_invalid && !it.is_filtered) begin
          hist_bins[bin] = sat_sum(hist_bins[bin], 32'd1);
          if (low_bin > bin) low_bin = bin;
          if (high_bin < bin) high_bin = bin;
          if (counted != 32'hFFFF_FFFF) begin
            counted++;
            level_total += 41'(it.level_dbm);
          end
        end
      end
      slhs_pkg::CMD_READ: begin
        cum = '0;
        for (int b = 0; b <= int'(bin); b++) cum = sat_sum(cum, hist_bins[b]);
        res.result_kind    = 1'b0;
        res.bin_count      = hist_bins[bin];
        res.bin_cumulative = cum;
        expected_results.push_back(res);
      end
      default: begin
        res.result_kind = 1'b1;
        if (counted == 0) begin
          res.is_empty = 1'b1;
        end else begin
          cum = '0; best = '0; med = 8'hFF; mod = '0; found = 1'b0;
          for (int b = 0; b < 256; b++) begin
            cum = sat_sum(cum, hist_bins[b]);
            if (!found && cum > (counted >> 1)) begin
              med = 8'(b);
              found = 1'b1;
            end
            if (hist_bins[b] > best) begin
              best = hist_bins[b];
              mod = 8'(b);
            end
          end
          mag  = (level_total < 0) ? 64'(-level_total) : 64'(level_total);
          q    = (mag * 64'd256) / 64'(counted);
          mean = (level_total < 0) ? 16'(-q) : 16'(q);
          res.total_count = counted;
          res.mean_q8     = mean;
          res.median_dbm  = med ^ 8'h80;
          res.mode_dbm    = mod ^ 8'h80;
          res.min_dbm     = low_bin ^ 8'h80;
          res.max_dbm     = high_bin ^ 8'h80;
        end
        expected_results.push_back(res);
      end
    endcase
  endtask

  // Offer one item; wait for its transfer and update the prediction
  task automatic send_item(slhs_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(it);
  endtask

  function automatic slhs_pkg::in_item_t make_item(logic [1:0] c, logic signed [7:0] lvl,
                                                   logic k, logic inv, logic filt);
    slhs_pkg::in_item_t it;
    it.cmd = c; it.level_dbm = lvl; it.kind_ok = k;
    it.level_invalid = inv; it.is_filtered = filt;
    return it;
  endfunction

  // Mostly well-formed adds clustered near a focus level, with rare reports
  function automatic slhs_pkg::in_item_t random_item();
    slhs_pkg::in_item_t it;
    int r;
    it = slhs_pkg::in_item_t'($urandom);
    r  = $urandom_range(999);
    if (r < 60)       it.cmd = slhs_pkg::CMD_SUMMARY;
    else if (r < 110) it.cmd = slhs_pkg::CMD_READ;
    else if (r < 118) it.cmd = slhs_pkg::CMD_CLEAR;
    else              it.cmd = slhs_pkg::CMD_ADD;
    if (it.cmd == slhs_pkg::CMD_ADD) begin
      if ($urandom_range(99) < 85) begin
        it.kind_ok = 1'b1; it.level_invalid = 1'b0; it.is_filtered = 1'b0;
      end
      if ($urandom_range(3) != 0)
        it.level_dbm = focus_level + 8'($urandom_range(8)) - 8'sd4;
    end else if (it.cmd == slhs_pkg::CMD_READ && $urandom_range(1) == 0) begin
      it.level_dbm = focus_level + 8'($urandom_range(8)) - 8'sd4;
    end
    return it;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, exp, $realtime);
    error_count++;
  endtask

  // Receiver: drive ready at the falling edge; check every output transfer
  always @(negedge clk) begin
    if (!rst) out_ch.ready <= !hold_off && ($urandom_range(99) >= receiver_stall);
  end

  always @(posedge clk) begin
    slhs_pkg::out_item_t got;
    slhs_pkg::out_item_t exp;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(got), 64'd0);
      end else begin
        exp = expected_results.pop_front();
        if (got.result_kind !== exp.result_kind)
          report_mismatch("result_kind", 64'(got.result_kind), 64'(exp.result_kind));
        if (got.bin_count !== exp.bin_count)
          report_mismatch("bin_count", 64'(got.bin_count), 64'(exp.bin_count));
        if (got.bin_cumulative !== exp.bin_cumulative)
          report_mismatch("bin_cumulative", 64'(got.bin_cumulative),
                          64'(exp.bin_cumulative));
        if (got.total_count !== exp.total_count)
          report_mismatch("total_count", 64'(got.total_count), 64'(exp.total_count));
        if (got.mean_q8 !== exp.mean_q8)
          report_mismatch("mean_q8", 64'(got.mean_q8), 64'(exp.mean_q8));
        if (got.median_dbm !== exp.median_dbm)
          report_mismatch("median_dbm", 64'(got.median_dbm), 64'(exp.median_dbm));
        if (got.mode_dbm !== exp.mode_dbm)
          report_mismatch("mode_dbm", 64'(got.mode_dbm), 64'(exp.mode_dbm));
        if (got.min_dbm !== exp.min_dbm)
          report_mismatch("min_dbm", 64'(got.min_dbm), 64'(exp.min_dbm));
        if (got.max_dbm !== exp.max_dbm)
          report_mismatch("max_dbm", 64'(got.max_dbm), 64'(exp.max_dbm));
        if (got.is_empty !== exp.is_empty)
          report_mismatch("is_empty", 64'(got.is_empty), 64'(exp.is_empty));
      end
    end
  end

  // Watchdog: count cycles without any transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Directed: empty reports, extreme levels, rejected samples, ties, clear
  task automatic test_directed();
    send_item(make_item(slhs_pkg::CMD_SUMMARY, 8'sd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_READ, -8'sd128, 1'b0, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_ADD, -8'sd128, 1'b1, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_ADD, 8'sd127, 1'b1, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_ADD, 8'sd0, 1'b1, 1'b0, 1'b0));
    // rejected samples must leave the histogram untouched
    send_item(make_item(slhs_pkg::CMD_ADD, 8'sd5, 1'b0, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_ADD, 8'sd6, 1'b1, 1'b1, 1'b0));
    send_item(make_item(slhs_pkg::CMD_ADD, 8'sd7, 1'b1, 1'b0, 1'b1));
    send_item(make_item(slhs_pkg::CMD_ADD, -8'sd1, 1'b0, 1'b1, 1'b1));
    send_item(make_item(slhs_pkg::CMD_READ, -8'sd128, 1'b1, 1'b1, 1'b1));
    send_item(make_item(slhs_pkg::CMD_READ, 8'sd127, 1'b0, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_READ, 8'sd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_SUMMARY, 8'sd0, 1'b1, 1'b1, 1'b1));
    // tie between three bins: mode takes the lowest one; mean goes negative
    send_item(make_item(slhs_pkg::CMD_ADD, -8'sd3, 1'b1, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_ADD, -8'sd3, 1'b1, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_ADD, 8'sd9, 1'b1, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_ADD, 8'sd9, 1'b1, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_ADD, -8'sd128, 1'b1, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_SUMMARY, -8'sd1, 1'b0, 1'b0, 1'b0));
    // clear ignores the other fields
    send_item(make_item(slhs_pkg::CMD_CLEAR, -8'sd1, 1'b1, 1'b1, 1'b1));
    send_item(make_item(slhs_pkg::CMD_SUMMARY, 8'sd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_READ, 8'sd127, 1'b0, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_ADD, 8'sd127, 1'b1, 1'b0, 1'b0));
    send_item(make_item(slhs_pkg::CMD_SUMMARY, 8'sd0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_random(int idle_pct, int stall_pct);
    slhs_pkg::in_item_t it;
    sender_idle    = idle_pct;
    receiver_stall = stall_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      it = random_item();
      if (it.cmd == slhs_pkg::CMD_CLEAR) focus_level = 8'($urandom);
      send_item(it);
    end
  endtask

  // Hold the receiver off while reports keep coming, so the input stalls
  task automatic test_backpressure();
    sender_idle    = 0;
    receiver_stall = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int n = 0; n < 30; n++) begin
      if (n % 3 == 0)
        send_item(make_item(slhs_pkg::CMD_SUMMARY, 8'sd0, 1'b0, 1'b0, 1'b0));
      else send_item(make_item(slhs_pkg::CMD_ADD, 8'($urandom), 1'b1, 1'b0, 1'b0));
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    clear_histogram();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(0, 0);
    test_random(72, 0);
    test_random(0, 72);
    test_random(23, 23);
    test_backpressure();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
